FILE: hdl/srtf_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// srtf_scheduler_top_defines
// Assertion helpers shared by the srtf scheduler rtl.
// ----------------------------------------------------------------------------
`ifndef SRTF_SCHEDULER_TOP_DEFINES_SVH
`define SRTF_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SRTF_ASSERT_IMP(label, ck, rstn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SRTF_ASSERT_NXT(label, ck, rstn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Types and constants shared by the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int MAX_JOBS  = 16;
  localparam int SLOT_BITS = $clog2(MAX_JOBS);
  localparam int TIME_BITS = 16;
  localparam int CMD_BITS  = 2;
  localparam int JC_BITS   = 5;

  localparam logic [CMD_BITS-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_RESTART = 2'd2;

  localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(MAX_JOBS - 1);
  localparam logic [JC_BITS-1:0]   JC_RESET  = JC_BITS'(1);

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [SLOT_BITS-1:0] slot;
    logic [TIME_BITS-1:0] arrival_time;
    logic [TIME_BITS-1:0] burst_time;
  } srtf_in_t;

  typedef struct packed {
    logic                 running_valid;
    logic [SLOT_BITS-1:0] running_slot;
    logic                 finished;
    logic [TIME_BITS-1:0] completion_time;
    logic [TIME_BITS-1:0] turnaround_time;
    logic [TIME_BITS-1:0] waiting_time;
    logic [TIME_BITS-1:0] response_time;
    logic                 all_done;
    logic [TIME_BITS-1:0] current_time;
  } srtf_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic do_load;
    logic do_restart;
    logic scan_init;
    logic scan_step;
    logic do_update;
    logic do_finish;
  } srtf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_load;
    logic is_restart;
    logic is_tick;
    logic all_done;
    logic scan_last;
    logic out_busy;
  } srtf_status_t;

endpackage

FILE: hdl/srtf_scheduler_top.sv
// ----------------------------------------------------------------------------
// srtf_scheduler_top
// Preemptive shortest-remaining-time-first scheduler over 16 job slots.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   srtf_in_t   (command, slot, times)
//   out_     output     out_valid/out_ready srtf_out_t  (one result per item)
//   cfg_     input      cfg_we              cfg_wdata   (job_count)
//
// A load, restart or unknown command goes from accept through dispatch
// to the result load. A tick, unless all jobs are done, also scans each
// slot for the minimum through a single shared table read port and updates.
// One item is in work at a time; the output register lets a result wait
// while the next item is accepted, and a full output stalls the last step.
// Reset (rst_n, synchronous, active low) empties all slots, clock at zero.
// ----------------------------------------------------------------------------
module srtf_scheduler_top import srtf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srtf_in_t           in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output srtf_out_t          out_item,
  input  logic               cfg_we,
  input  logic [JC_BITS-1:0] cfg_wdata
);

  srtf_cmd_t    cmd;
  srtf_status_t st;

  srtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  srtf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: hdl/srtf_ctrl.sv
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer: accepts an item, dispatches it, runs the slot scan and update.
// ----------------------------------------------------------------------------
module srtf_ctrl import srtf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  srtf_status_t st,
  output srtf_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_UPDATE   = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (st.is_load) begin
          cmd.do_load = 1'b1;
          state_nxt   = S_FINISH;
        end else if (st.is_restart) begin
          cmd.do_restart = 1'b1;
          state_nxt      = S_FINISH;
        end else if (st.is_tick && !st.all_done) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.do_update = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        // wait for room in the output register
        if (!st.out_busy) begin
          cmd.do_finish = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/srtf_dp.sv
// ----------------------------------------------------------------------------
// srtf_dp
// Slot tables, clock, minimum-remaining scan and result registers.
// ----------------------------------------------------------------------------
`include "srtf_scheduler_top_defines.svh"

module srtf_dp import srtf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [JC_BITS-1:0] cfg_wdata,
  input  srtf_in_t           in_item,
  output srtf_out_t          out_item,
  output logic               out_valid,
  input  logic               out_ready,
  input  srtf_cmd_t          cmd,
  output srtf_status_t       st
);

  logic [JC_BITS-1:0]   job_count_r;
  srtf_in_t             in_r;
  logic [TIME_BITS-1:0] arr_mem [MAX_JOBS];
  logic [TIME_BITS-1:0] bur_mem [MAX_JOBS];
  logic [TIME_BITS-1:0] resp_mem [MAX_JOBS];
  logic [TIME_BITS-1:0] rem_r [MAX_JOBS];
  logic [MAX_JOBS-1:0]  started_r;
  logic [MAX_JOBS-1:0]  done_r;
  logic [TIME_BITS-1:0] clk_r;
  logic [SLOT_BITS-1:0] idx_r;
  logic [SLOT_BITS-1:0] best_r;
  logic [TIME_BITS-1:0] best_rem_r;
  logic                 found_r;
  srtf_out_t            res_r;
  srtf_out_t            out_r;
  logic                 out_valid_r;

  logic [MAX_JOBS-1:0]  active_mask;
  logic                 all_done;
  logic                 load_ok;
  logic [SLOT_BITS-1:0] rd_idx;
  logic [TIME_BITS-1:0] rd_arr;
  logic [TIME_BITS-1:0] rd_rem;
  logic [TIME_BITS-1:0] rd_bur;
  logic                 better;
  logic [TIME_BITS-1:0] clk_inc;
  logic [TIME_BITS-1:0] resp_val;
  logic                 fin_now;
  logic [TIME_BITS-1:0] tat_val;
  logic [TIME_BITS-1:0] wt_val;
  srtf_out_t            res_fin;

  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      active_mask[i] = (i < int'(job_count_r));
    end
  end

  assign all_done = &(done_r | ~active_mask);
  assign load_ok  = (in_r.burst_time != '0);

  // one shared read port: scan index while scanning, chosen slot otherwise
  assign rd_idx = cmd.scan_step ? idx_r : best_r;
  assign rd_arr = arr_mem[rd_idx];
  assign rd_rem = rem_r[rd_idx];
  assign rd_bur = bur_mem[best_r];

  assign better = active_mask[idx_r] && !done_r[idx_r] && (rd_arr <= clk_r) &&
                  (!found_r || (rd_rem < best_rem_r));

  assign clk_inc  = (clk_r == TIME_MAX) ? clk_r : clk_r + TIME_BITS'(1);
  assign resp_val = started_r[best_r] ? resp_mem[best_r] : clk_r - rd_arr;
  assign fin_now  = found_r && (rd_rem <= TIME_BITS'(1));
  assign tat_val  = (clk_inc >= rd_arr) ? clk_inc - rd_arr : '0;
  assign wt_val   = (res_r.finished && (res_r.turnaround_time >= rd_bur)) ?
                    res_r.turnaround_time - rd_bur : '0;

  // result as it leaves for the output register
  always_comb begin
    res_fin              = res_r;
    res_fin.waiting_time = wt_val;
    res_fin.all_done     = all_done;
    res_fin.current_time = clk_r;
  end

  assign st.is_load    = (in_r.command == CMD_LOAD);
  assign st.is_restart = (in_r.command == CMD_RESTART);
  assign st.is_tick    = (in_r.command == CMD_TICK);
  assign st.all_done   = all_done;
  assign st.scan_last  = (idx_r == SLOT_LAST);
  assign st.out_busy   = out_valid_r && !out_ready;

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_count_r <= JC_RESET;
      rem_r       <= '{default: '0};
      started_r   <= '0;
      done_r      <= '1;
      clk_r       <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        job_count_r <= cfg_wdata;
      end
      if (cmd.do_load && load_ok) begin
        rem_r[in_r.slot]     <= in_r.burst_time;
        started_r[in_r.slot] <= 1'b0;
        done_r[in_r.slot]    <= 1'b0;
      end
      if (cmd.do_restart) begin
        clk_r <= '0;
      end
      if (cmd.scan_init) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + SLOT_BITS'(1);
        if (better) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.do_update) begin
        clk_r <= clk_inc;
        if (found_r) begin
          started_r[best_r] <= 1'b1;
          rem_r[best_r]     <= rd_rem - TIME_BITS'(rd_rem != '0);
          if (fin_now) begin
            done_r[best_r] <= 1'b1;
          end
        end
      end
      if (cmd.do_finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r  <= in_item;
      res_r <= '0;
    end
    if (cmd.do_load && load_ok) begin
      arr_mem[in_r.slot] <= in_r.arrival_time;
      bur_mem[in_r.slot] <= in_r.burst_time;
    end
    if (cmd.scan_step && better) begin
      best_r     <= idx_r;
      best_rem_r <= rd_rem;
    end
    if (cmd.do_update && found_r) begin
      if (!started_r[best_r]) begin
        resp_mem[best_r] <= resp_val;
      end
      res_r.running_valid   <= 1'b1;
      res_r.running_slot    <= best_r;
      res_r.finished        <= fin_now;
      res_r.completion_time <= fin_now ? clk_inc : '0;
      res_r.turnaround_time <= fin_now ? tat_val : '0;
      res_r.response_time   <= fin_now ? resp_val : '0;
    end
    if (cmd.do_finish) begin
      out_r <= res_fin;
    end
  end

  `SRTF_ASSERT_IMP(a_fin_runs, clk, rst_n, out_valid_r && out_r.finished,
    out_r.running_valid && (out_r.completion_time == out_r.current_time),
    "finished item without a running slot or with a stale completion time")

  `SRTF_ASSERT_NXT(a_fin_marks_done, clk, rst_n, cmd.do_update && fin_now,
    done_r[$past(best_r)], "finishing slot not marked done")

  `SRTF_ASSERT_NXT(a_clk_monotonic, clk, rst_n, !cmd.do_restart,
    clk_r >= $past(clk_r), "clock moved backward without a restart")

endmodule
